### rtl/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared constants and types for the CAN analyzer packet deframer.
// ----------------------------------------------------------------------------
package ucd_pkg;

  localparam logic [7:0] MARK_START = 8'hAA;
  localparam logic [7:0] MARK_END   = 8'h55;
  localparam logic [7:0] TYPE_BASE  = 8'hC0;
  localparam logic [7:0] TYPE_EXT   = 8'h20;
  localparam logic [7:0] TYPE_RTR   = 8'h10;
  localparam logic [7:0] TYPE_DLC   = 8'h0F;
  localparam logic [4:0] SETTINGS_LEN = 5'd20;
  localparam logic [3:0] MAX_DLC    = 4'd8;
  localparam logic [2:0] MAX_OUT    = 3'd4;

  // Buffer read address selection, relative to the head of the buffer.
  localparam logic [1:0] RD_HEAD  = 2'd0;
  localparam logic [1:0] RD_TYPE  = 2'd1;
  localparam logic [1:0] RD_LAST  = 2'd2;
  localparam logic [1:0] RD_FIELD = 2'd3;

  typedef struct packed {
    logic [31:0] can_id;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic        last_of_run;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap_byte;
    logic       drop_one;
    logic       drop_total;
    logic       drop_set;
    logic       append;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_type;
    logic       k_init;
    logic       gather;
    logic       load_pend;
    logic       push_out;
    logic       push_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic lt_two;
    logic lt_set;
    logic lt_total;
    logic byte_aa;
    logic rd_aa;
    logic rd_55;
    logic type_55;
    logic type_bad;
    logic k_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/ucd_intf.sv
// ----------------------------------------------------------------------------
// ucd_in_if / ucd_out_if
// Valid/ready channels for received bytes and decoded CAN frames.
// ----------------------------------------------------------------------------
interface ucd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] can_id;
  logic        is_extended;
  logic        is_remote;
  logic [3:0]  data_length;
  logic [63:0] payload;
  logic        last_of_run;

  modport source (output valid, output can_id, output is_extended, output is_remote,
                  output data_length, output payload, output last_of_run, input ready);
  modport sink   (input valid, input can_id, input is_extended, input is_remote,
                  input data_length, input payload, input last_of_run, output ready);
endinterface

### rtl/ucd_ctrl.sv
// ----------------------------------------------------------------------------
// ucd_ctrl
// Sequencer that steps the deframer through append, resync and decode.
// ----------------------------------------------------------------------------
module ucd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ucd_pkg::stat_t stat,
  output ucd_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ENTER  = 4'd1;
  localparam logic [3:0] S_APPEND = 4'd2;
  localparam logic [3:0] S_ALIGN  = 4'd3;
  localparam logic [3:0] S_ACHK   = 4'd4;
  localparam logic [3:0] S_LOOP   = 4'd5;
  localparam logic [3:0] S_TYPE   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_TAIL   = 4'd8;
  localparam logic [3:0] S_FETCH  = 4'd9;
  localparam logic [3:0] S_GATHER = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;
  localparam logic [3:0] S_FINISH = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       pre_r, pre_nxt;       // aligning before the append of a full buffer
  logic [1:0] n_r, n_nxt;           // frames decoded for this byte
  logic       pend_r, pend_nxt;     // a decoded frame waits in the staging register

  // No byte is taken while reset is held.
  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pre_nxt   = pre_r;
    n_nxt     = n_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_byte = 1'b1;
          state_nxt    = S_ENTER;
        end
      end
      S_ENTER: begin
        if (stat.full) begin
          cmd.drop_one = 1'b1;
          pre_nxt      = 1'b1;
          state_nxt    = S_ALIGN;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        pre_nxt = 1'b0;
        if (stat.empty && !stat.byte_aa) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.append = 1'b1;
          n_nxt      = 2'd0;
          state_nxt  = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (stat.empty) begin
          state_nxt = pre_r ? S_APPEND : S_LOOP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ucd_pkg::RD_HEAD;
          state_nxt  = S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat.rd_aa) begin
          state_nxt = pre_r ? S_APPEND : S_LOOP;
        end else begin
          cmd.drop_one = 1'b1;
          state_nxt    = S_ALIGN;
        end
      end
      S_LOOP: begin
        if (stat.lt_two) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ucd_pkg::RD_TYPE;
          state_nxt  = S_TYPE;
        end
      end
      S_TYPE: begin
        cmd.cap_type = 1'b1;
        state_nxt    = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.type_55) begin
          if (stat.lt_set) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.drop_set = 1'b1;
            state_nxt    = S_ALIGN;
          end
        end else if (stat.type_bad) begin
          cmd.drop_one = 1'b1;
          state_nxt    = S_ALIGN;
        end else if (stat.lt_total) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ucd_pkg::RD_LAST;
          state_nxt  = S_TAIL;
        end
      end
      S_TAIL: begin
        if (stat.rd_55) begin
          cmd.k_init = 1'b1;
          state_nxt  = S_FETCH;
        end else begin
          cmd.drop_one = 1'b1;
          state_nxt    = S_ALIGN;
        end
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ucd_pkg::RD_FIELD;
        state_nxt  = S_GATHER;
      end
      S_GATHER: begin
        cmd.gather = 1'b1;
        state_nxt  = stat.k_last ? S_EMIT : S_FETCH;
      end
      S_EMIT: begin
        // The previous frame moves on only when the output register can take it.
        if (!pend_r || stat.out_free) begin
          cmd.push_out   = pend_r;
          cmd.load_pend  = 1'b1;
          cmd.drop_total = 1'b1;
          pend_nxt       = 1'b1;
          n_nxt          = n_r + 2'd1;
          if ({1'b0, n_r} == ucd_pkg::MAX_OUT - 3'd1) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_ALIGN;
          end
        end
      end
      S_FINISH: begin
        if (!pend_r) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.push_out  = 1'b1;
          cmd.push_last = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pre_r   <= 1'b0;
      n_r     <= 2'd0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pre_r   <= pre_nxt;
      n_r     <= n_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

### rtl/ucd_dp.sv
// ----------------------------------------------------------------------------
// ucd_dp
// Circular byte buffer, frame field assembly and the result registers.
// ----------------------------------------------------------------------------
module ucd_dp #(
  parameter int BUFFER_BYTES = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_byte,
  input  ucd_pkg::cmd_t    cmd,
  output ucd_pkg::stat_t   stat,
  output logic             out_valid,
  input  logic             out_ready,
  output ucd_pkg::result_t out_data
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int OW = (CW > 5) ? CW : 5;

  logic [7:0]       mem [BUFFER_BYTES];
  logic [7:0]       rdata_r;
  logic [AW-1:0]    head_r;
  logic [CW-1:0]    count_r;
  logic [7:0]       byte_r;
  logic [7:0]       type_r;
  logic [3:0]       k_r;
  logic [31:0]      id_r;
  logic [63:0]      data_r;
  ucd_pkg::result_t pend_r;
  ucd_pkg::result_t out_r;
  logic             out_valid_r;

  logic [3:0]    dlc;
  logic [2:0]    idlen;
  logic [4:0]    total;
  logic [3:0]    j;
  logic [3:0]    jd;
  logic [OW-1:0] rd_off;
  logic [OW-1:0] drop_amt;
  logic [OW-1:0] count_w;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] head_adv;

  // Head plus an offset, folded back into the buffer with one subtract.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [OW-1:0] off);
    logic [OW:0] sum;
    sum = {{(OW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (sum >= (OW + 1)'(BUFFER_BYTES)) begin
      sum = sum - (OW + 1)'(BUFFER_BYTES);
    end
    return sum[AW-1:0];
  endfunction

  assign dlc     = type_r[3:0] & ucd_pkg::TYPE_DLC[3:0];
  assign idlen   = ((type_r & ucd_pkg::TYPE_EXT) != 8'd0) ? 3'd4 : 3'd2;
  assign total   = 5'd3 + {2'b00, idlen} + {1'b0, dlc};
  assign j       = k_r - 4'd2;
  assign jd      = j - {1'b0, idlen};
  assign count_w = {{(OW - CW){1'b0}}, count_r};

  always_comb begin
    case (cmd.rd_sel)
      ucd_pkg::RD_HEAD:  rd_off = '0;
      ucd_pkg::RD_TYPE:  rd_off = OW'(1);
      ucd_pkg::RD_LAST:  rd_off = OW'(total - 5'd1);
      ucd_pkg::RD_FIELD: rd_off = OW'(k_r);
      default:           rd_off = '0;
    endcase
    if (cmd.drop_total) begin
      drop_amt = OW'(total);
    end else if (cmd.drop_set) begin
      drop_amt = OW'(ucd_pkg::SETTINGS_LEN);
    end else begin
      drop_amt = OW'(1);
    end
  end

  assign rd_addr  = wrap(head_r, rd_off);
  assign wr_addr  = wrap(head_r, count_w);
  assign head_adv = wrap(head_r, drop_amt);

  always_comb begin
    stat.full     = (count_r == CW'(BUFFER_BYTES));
    stat.empty    = (count_r == '0);
    stat.lt_two   = (count_w < OW'(2));
    stat.lt_set   = (count_w < OW'(ucd_pkg::SETTINGS_LEN));
    stat.lt_total = (count_w < OW'(total));
    stat.byte_aa  = (byte_r == ucd_pkg::MARK_START);
    stat.rd_aa    = (rdata_r == ucd_pkg::MARK_START);
    stat.rd_55    = (rdata_r == ucd_pkg::MARK_END);
    stat.type_55  = (type_r == ucd_pkg::MARK_END);
    stat.type_bad = ((type_r & ucd_pkg::TYPE_BASE) != ucd_pkg::TYPE_BASE) ||
                    (dlc > ucd_pkg::MAX_DLC);
    stat.k_last   = ({1'b0, k_r} == total - 5'd2);
    stat.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_addr] <= byte_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.drop_one || cmd.drop_total || cmd.drop_set) begin
        head_r  <= head_adv;
        count_r <= CW'(count_w - drop_amt);
      end
      if (cmd.push_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_byte) begin
      byte_r <= in_byte;
    end
    if (cmd.cap_type) begin
      type_r <= rdata_r;
    end
    if (cmd.k_init) begin
      k_r    <= 4'd2;
      id_r   <= '0;
      data_r <= '0;
    end else if (cmd.gather) begin
      k_r <= k_r + 4'd1;
      if (j < {1'b0, idlen}) begin
        id_r[{j[1:0], 3'b000} +: 8] <= rdata_r;
      end else begin
        data_r[{jd[2:0], 3'b000} +: 8] <= rdata_r;
      end
    end
    if (cmd.push_out) begin
      out_r <= '{can_id:      pend_r.can_id,
                 is_extended: pend_r.is_extended,
                 is_remote:   pend_r.is_remote,
                 data_length: pend_r.data_length,
                 payload:     pend_r.payload,
                 last_of_run: cmd.push_last};
    end
    if (cmd.load_pend) begin
      pend_r <= '{can_id:      id_r,
                  is_extended: (type_r & ucd_pkg::TYPE_EXT) != 8'd0,
                  is_remote:   (type_r & ucd_pkg::TYPE_RTR) != 8'd0,
                  data_length: dlc,
                  payload:     data_r,
                  last_of_run: 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/usb_can_packet_deframer.sv
// Input: a new byte is taken only after the controller's decode loop for the last byte,
//   which reads the buffer memory one byte at a time through its single read port.
// Reset: synchronous, active low; the buffer empties and no result is pending.
// ----------------------------------------------------------------------------
// usb_can_packet_deframer
// Deframes the variable-length serial packets of a USB-CAN analyzer into CAN
// frames: identifier, extended and remote flags, DLC and payload.
// ----------------------------------------------------------------------------
//
// Structure
//   ucd_ctrl is the sequencer. It accepts one byte at a time, appends it to
//   the buffer, then runs the decode loop: align the head of the buffer on
//   0xAA, fetch the type byte, classify it, check the closing 0x55 and gather
//   the identifier and data bytes one memory read at a time.
//   ucd_dp holds the circular byte buffer (head pointer plus fill count, so a
//   dropped prefix costs no data movement), the field assembly registers, a
//   staging register for the most recent frame and the output register.
//
// Results
//   A decoded frame first waits in the staging register. It is only handed to
//   the output register once the next frame has been found or the loop has
//   ended, because only then is it known whether it is the final frame of the
//   run that the current byte triggered. At most four frames are decoded per
//   byte; anything left behind stays buffered for the next byte.
//
// Flow control
//   A new byte is taken as soon as the sequencer is back at rest, even while
//   the last result transaction of the previous byte is still waiting in the
//   output register. The sequencer stalls whenever the staging register must
//   hand a frame to the output register while that register is still
//   occupied, either when a further frame is found or when the run ends.
// ----------------------------------------------------------------------------
module usb_can_packet_deframer #(
  parameter int BUFFER_BYTES = 20
) (
  input logic       clk,
  input logic       rst_n,
  ucd_in_if.sink    in_ch,
  ucd_out_if.source out_ch
);

  ucd_pkg::cmd_t    cmd;
  ucd_pkg::stat_t   stat;
  ucd_pkg::result_t res;
  logic             in_ready;
  logic             out_valid;

  ucd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ucd_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.can_id      = res.can_id;
  assign out_ch.is_extended = res.is_extended;
  assign out_ch.is_remote   = res.is_remote;
  assign out_ch.data_length = res.data_length;
  assign out_ch.payload     = res.payload;
  assign out_ch.last_of_run = res.last_of_run;

endmodule

### rtl/ucd_chk.sv
// ----------------------------------------------------------------------------
// ucd_chk
// Port-level checks of the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ucd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_can_id,
  input logic        out_is_extended,
  input logic [3:0]  out_data_length,
  input logic [63:0] out_payload,
  input logic        out_last_of_run
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(out_can_id) &&
    $stable(out_last_of_run))
    else $error("result changed while stalled");

  // The input is not ready again right after an accepted byte.
  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accepted byte");

  a_dlc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data_length <= 4'd8)
    else $error("data length above eight");

  // Payload bytes beyond the data length read as zero.
  a_payload_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload >> {out_data_length, 3'b000}) == 64'd0)
    else $error("payload bytes beyond the data length are not zero");

  // A standard frame carries a two-byte identifier.
  a_std_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_extended |-> out_can_id[31:16] == 16'd0)
    else $error("standard identifier wider than two bytes");

endmodule

bind usb_can_packet_deframer ucd_chk u_ucd_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_can_id      (out_ch.can_id),
  .out_is_extended (out_ch.is_extended),
  .out_data_length (out_ch.data_length),
  .out_payload     (out_ch.payload),
  .out_last_of_run (out_ch.last_of_run)
);
